// ===== rtl/co2bc_pkg.sv =====
// co2bc_pkg: shared constants, types and helpers for the co2 baseline calibrator
// no dependencies; imported by every rtl module of the block

package co2bc_pkg;

    localparam int MONTH_SLOTS = 12;
    localparam int SLOT_W      = $clog2(MONTH_SLOTS);
    localparam int PPM_W       = 16;
    localparam int MONTH_W     = 4;
    localparam int YEAR_W      = 10;
    localparam int STAMP_W     = 14;
    localparam int BASE_W      = 12;
    localparam int GROW_W      = 4;
    localparam int LOOK_W      = 4;
    localparam int CNT_W       = 4;
    localparam int PADDR_W     = 5;
    localparam int PDATA_W     = 32;

    localparam logic [SLOT_W-1:0] LAST_SLOT  = SLOT_W'(MONTH_SLOTS - 1);
    localparam logic [LOOK_W-1:0] MAX_LOOK   = LOOK_W'(MONTH_SLOTS);
    localparam logic [PPM_W-1:0]  PPM_MAX    = '1;

    localparam logic [PPM_W-1:0]  RST_MIN_VALID = PPM_W'(200);
    localparam logic [LOOK_W-1:0] RST_LOOKBACK  = LOOK_W'(6);
    localparam logic [LOOK_W-1:0] RST_REQUIRED  = LOOK_W'(5);
    localparam logic [BASE_W-1:0] RST_BASELINE  = BASE_W'(421);
    localparam logic [YEAR_W-1:0] RST_BASE_YEAR = YEAR_W'(123);
    localparam logic [GROW_W-1:0] RST_GROWTH    = GROW_W'(2);

    typedef enum logic [2:0] {
        REG_MIN_VALID = 3'd0,
        REG_LOOKBACK  = 3'd1,
        REG_REQUIRED  = 3'd2,
        REG_BASELINE  = 3'd3,
        REG_BASE_YEAR = 3'd4,
        REG_GROWTH    = 3'd5
    } t_reg_idx;

    typedef struct packed {
        logic [PPM_W-1:0]  min_valid;
        logic [LOOK_W-1:0] lookback;
        logic [LOOK_W-1:0] required;
        logic [BASE_W-1:0] baseline;
        logic [YEAR_W-1:0] base_year;
        logic [GROW_W-1:0] growth;
    } t_cfg;

    typedef struct packed {
        logic              en;
        logic [SLOT_W-1:0] addr;
        logic [PPM_W-1:0]  data;
    } t_ring_wr;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_CLEAR,
        S_WRITE,
        S_SCAN,
        S_CALC,
        S_DONE
    } t_state;

    function automatic logic [SLOT_W-1:0] prev_slot(input logic [SLOT_W-1:0] s);
        logic [SLOT_W-1:0] p;
        p = (s == '0) ? LAST_SLOT : s - 1'b1;
        return p;
    endfunction

endpackage

// ===== rtl/co2_baseline_calibrator.sv =====
// co2_baseline_calibrator: top level, register port, sequencer and month ring
// sequence: check, clear of g skipped months (0..11), write, scan of L lookback slots
// (1..12), calc and done; a rejected reading goes from check straight to done
// one item at a time: the input stalls until done hands on the result, which waits on the output stall
// reset: synchronous active low; registers to defaults, ring, stamp and offset to 0
// depends on co2bc_pkg, co2bc_ring, co2bc_core

module co2_baseline_calibrator
    import co2bc_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [PADDR_W-1:0]        paddr,
    input  logic [PDATA_W-1:0]        pwdata,
    output logic [PDATA_W-1:0]        prdata,
    output logic                      pready,
    input  logic                      i_in_valid,
    output logic                      o_in_stall,
    input  logic [PPM_W-1:0]          i_reading_ppm,
    input  logic [MONTH_W-1:0]        i_month_index,
    input  logic [YEAR_W-1:0]         i_year_index,
    output logic                      o_out_valid,
    input  logic                      i_out_stall,
    output logic signed [PPM_W-1:0]   o_offset_ppm,
    output logic                      o_persist_needed,
    output logic                      o_reading_rejected
);

    t_cfg              r_cfg;
    t_reg_idx          reg_idx;
    logic              cfg_wr;
    t_ring_wr          ring_wr;
    logic [SLOT_W-1:0] ring_rd_addr;
    logic [PPM_W-1:0]  ring_rd_data;
    logic [PPM_W-1:0]  offset_bits;

    assign pready  = 1'b1;
    assign reg_idx = t_reg_idx'(paddr[PADDR_W-1:2]);
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.min_valid <= RST_MIN_VALID;
            r_cfg.lookback  <= RST_LOOKBACK;
            r_cfg.required  <= RST_REQUIRED;
            r_cfg.baseline  <= RST_BASELINE;
            r_cfg.base_year <= RST_BASE_YEAR;
            r_cfg.growth    <= RST_GROWTH;
        end else if (cfg_wr) begin
            unique case (reg_idx)
                REG_MIN_VALID: r_cfg.min_valid <= pwdata[PPM_W-1:0];
                REG_LOOKBACK:  r_cfg.lookback  <= pwdata[LOOK_W-1:0];
                REG_REQUIRED:  r_cfg.required  <= pwdata[LOOK_W-1:0];
                REG_BASELINE:  r_cfg.baseline  <= pwdata[BASE_W-1:0];
                REG_BASE_YEAR: r_cfg.base_year <= pwdata[YEAR_W-1:0];
                REG_GROWTH:    r_cfg.growth    <= pwdata[GROW_W-1:0];
                default:       r_cfg           <= r_cfg;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_MIN_VALID: prdata = PDATA_W'(r_cfg.min_valid);
            REG_LOOKBACK:  prdata = PDATA_W'(r_cfg.lookback);
            REG_REQUIRED:  prdata = PDATA_W'(r_cfg.required);
            REG_BASELINE:  prdata = PDATA_W'(r_cfg.baseline);
            REG_BASE_YEAR: prdata = PDATA_W'(r_cfg.base_year);
            REG_GROWTH:    prdata = PDATA_W'(r_cfg.growth);
            default:       prdata = '0;
        endcase
    end

    co2bc_ring u_ring (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr      (ring_wr),
        .i_rd_addr (ring_rd_addr),
        .o_rd_data (ring_rd_data)
    );

    co2bc_core u_core (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg              (r_cfg),
        .i_in_valid         (i_in_valid),
        .o_in_stall         (o_in_stall),
        .i_reading_ppm      (i_reading_ppm),
        .i_month_index      (i_month_index),
        .i_year_index       (i_year_index),
        .o_out_valid        (o_out_valid),
        .i_out_stall        (i_out_stall),
        .o_offset_ppm       (offset_bits),
        .o_persist_needed   (o_persist_needed),
        .o_reading_rejected (o_reading_rejected),
        .o_ring_wr          (ring_wr),
        .o_ring_rd_addr     (ring_rd_addr),
        .i_ring_rd_data     (ring_rd_data)
    );

    assign o_offset_ppm = $signed(offset_bits);

endmodule

// ===== rtl/co2bc_ring.sv =====
// co2bc_ring: ring of per-month minimum readings, one write and one read port
// depends on co2bc_pkg; all slots clear to zero at reset

module co2bc_ring
    import co2bc_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_ring_wr          i_wr,
    input  logic [SLOT_W-1:0] i_rd_addr,
    output logic [PPM_W-1:0]  o_rd_data
);

    logic [PPM_W-1:0] r_slot_min [MONTH_SLOTS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < MONTH_SLOTS; k++) begin
                r_slot_min[k] <= '0;
            end
        end else if (i_wr.en) begin
            r_slot_min[i_wr.addr] <= i_wr.data;
        end
    end

    assign o_rd_data = r_slot_min[i_rd_addr];

endmodule

// ===== rtl/co2bc_core.sv =====
// co2bc_core: sequencer with one shared comparator that updates the month ring,
// scans it for the minimum and forms the offset; depends on co2bc_pkg

module co2bc_core
    import co2bc_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cfg               i_cfg,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [PPM_W-1:0]   i_reading_ppm,
    input  logic [MONTH_W-1:0] i_month_index,
    input  logic [YEAR_W-1:0]  i_year_index,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic [PPM_W-1:0]   o_offset_ppm,
    output logic               o_persist_needed,
    output logic               o_reading_rejected,
    output t_ring_wr           o_ring_wr,
    output logic [SLOT_W-1:0]  o_ring_rd_addr,
    input  logic [PPM_W-1:0]   i_ring_rd_data
);

    t_state r_state, n_state;

    logic [PPM_W-1:0]   r_reading, n_reading;
    logic [MONTH_W-1:0] r_month, n_month;
    logic [YEAR_W-1:0]  r_year, n_year;
    logic [STAMP_W-1:0] r_last_stamp, n_last_stamp;
    logic [PPM_W-1:0]   r_held, n_held;
    logic [SLOT_W-1:0]  r_slot, n_slot;
    logic [SLOT_W-1:0]  r_idx, n_idx;
    logic [CNT_W-1:0]   r_cnt, n_cnt;
    logic [PPM_W-1:0]   r_min, n_min;
    logic [CNT_W-1:0]   r_count, n_count;
    logic               r_same, n_same;
    logic               r_changed, n_changed;
    logic               r_rejected, n_rejected;
    logic               r_out_valid, n_out_valid;
    logic [PPM_W-1:0]   r_out_offset, n_out_offset;
    logic               r_out_persist, n_out_persist;
    logic               r_out_rejected, n_out_rejected;

    logic               accept;
    logic               out_free;
    logic [PPM_W-1:0]   cmp_a, cmp_b;
    logic               cmp_lt;
    logic [STAMP_W-1:0] stamp;
    logic [STAMP_W-1:0] stamp_delta;
    logic [SLOT_W-1:0]  slot;
    logic               advance;
    logic [CNT_W-1:0]   gap;
    logic [LOOK_W-1:0]  look;
    logic [LOOK_W-1:0]  need;
    logic signed [YEAR_W:0]  year_diff;
    logic signed [PPM_W-1:0] growth_term;
    logic [PPM_W-1:0]   offset_calc;
    logic               slot_write;

    assign accept   = i_in_valid && (r_state == S_IDLE);
    assign out_free = !r_out_valid || !i_out_stall;
    assign cmp_lt   = cmp_a < cmp_b;

    // month stamp and ring slot
    assign stamp   = STAMP_W'({r_year, 3'b000}) + STAMP_W'({r_year, 2'b00})
                   + STAMP_W'(r_month);
    assign slot    = (r_month >= MONTH_W'(MONTH_SLOTS))
                   ? SLOT_W'(r_month - MONTH_W'(MONTH_SLOTS)) : SLOT_W'(r_month);
    assign advance = stamp > r_last_stamp;
    assign stamp_delta = stamp - r_last_stamp - 1'b1;
    assign gap     = (stamp_delta > STAMP_W'(LAST_SLOT)) ? CNT_W'(LAST_SLOT)
                   : CNT_W'(stamp_delta);

    assign look = (i_cfg.lookback == '0) ? LOOK_W'(1)
                : (i_cfg.lookback > MAX_LOOK) ? MAX_LOOK : i_cfg.lookback;
    assign need = (i_cfg.required == '0) ? LOOK_W'(1) : i_cfg.required;

    // offset arithmetic, kept modulo 2^16
    assign year_diff   = $signed({1'b0, r_year}) - $signed({1'b0, i_cfg.base_year});
    assign growth_term = year_diff * $signed({1'b0, i_cfg.growth});
    assign offset_calc = PPM_W'(i_cfg.baseline) + $unsigned(growth_term) - r_min;

    assign slot_write = !r_same || (i_ring_rd_data == '0) || cmp_lt;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (accept) n_state = S_CHECK;
            end
            S_CHECK: begin
                if (cmp_lt) n_state = S_DONE;
                else if (advance && (gap != '0)) n_state = S_CLEAR;
                else n_state = S_WRITE;
            end
            S_CLEAR: begin
                if (r_cnt == CNT_W'(1)) n_state = S_WRITE;
            end
            S_WRITE: begin
                n_state = S_SCAN;
            end
            S_SCAN: begin
                if (r_cnt == CNT_W'(1)) n_state = S_CALC;
            end
            S_CALC: begin
                n_state = S_DONE;
            end
            S_DONE: begin
                if (out_free) n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // ring port and shared comparator operands
    always_comb begin
        o_ring_wr      = '0;
        o_ring_rd_addr = r_slot;
        cmp_a          = '0;
        cmp_b          = '0;
        unique case (r_state)
            S_CHECK: begin
                cmp_a = r_reading;
                cmp_b = i_cfg.min_valid;
            end
            S_CLEAR: begin
                o_ring_wr.en   = 1'b1;
                o_ring_wr.addr = r_idx;
                o_ring_wr.data = '0;
            end
            S_WRITE: begin
                cmp_a          = r_reading;
                cmp_b          = i_ring_rd_data;
                o_ring_wr.en   = slot_write;
                o_ring_wr.addr = r_slot;
                o_ring_wr.data = r_reading;
            end
            S_SCAN: begin
                o_ring_rd_addr = r_idx;
                cmp_a          = i_ring_rd_data;
                cmp_b          = r_min;
            end
            default: begin
                o_ring_wr = '0;
            end
        endcase
    end

    // datapath next values
    always_comb begin
        n_reading      = r_reading;
        n_month        = r_month;
        n_year         = r_year;
        n_last_stamp   = r_last_stamp;
        n_held         = r_held;
        n_slot         = r_slot;
        n_idx          = r_idx;
        n_cnt          = r_cnt;
        n_min          = r_min;
        n_count        = r_count;
        n_same         = r_same;
        n_changed      = r_changed;
        n_rejected     = r_rejected;
        n_out_valid    = r_out_valid && i_out_stall;
        n_out_offset   = r_out_offset;
        n_out_persist  = r_out_persist;
        n_out_rejected = r_out_rejected;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_reading = i_reading_ppm;
                    n_month   = i_month_index;
                    n_year    = i_year_index;
                end
            end
            S_CHECK: begin
                n_changed  = 1'b0;
                n_rejected = cmp_lt;
                if (!cmp_lt) begin
                    n_slot       = slot;
                    n_same       = (stamp == r_last_stamp);
                    n_last_stamp = stamp;
                    n_idx        = prev_slot(slot);
                    n_cnt        = gap;
                end
            end
            S_CLEAR: begin
                n_idx = prev_slot(r_idx);
                n_cnt = r_cnt - 1'b1;
            end
            S_WRITE: begin
                if (slot_write) n_changed = 1'b1;
                n_idx   = r_slot;
                n_cnt   = CNT_W'(look);
                n_min   = PPM_MAX;
                n_count = '0;
            end
            S_SCAN: begin
                if (i_ring_rd_data != '0) begin
                    n_count = r_count + 1'b1;
                    if (cmp_lt) n_min = i_ring_rd_data;
                end
                n_idx = prev_slot(r_idx);
                n_cnt = r_cnt - 1'b1;
            end
            S_CALC: begin
                if ((r_count >= CNT_W'(need)) && (offset_calc != r_held)) begin
                    n_held    = offset_calc;
                    n_changed = 1'b1;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    n_out_valid    = 1'b1;
                    n_out_offset   = r_held;
                    n_out_persist  = r_changed;
                    n_out_rejected = r_rejected;
                end
            end
            default: begin
                n_cnt = r_cnt;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_out_valid  <= 1'b0;
            r_last_stamp <= '0;
            r_held       <= '0;
        end else begin
            r_state      <= n_state;
            r_out_valid  <= n_out_valid;
            r_last_stamp <= n_last_stamp;
            r_held       <= n_held;
        end
    end

    always_ff @(posedge i_clk) begin
        r_reading      <= n_reading;
        r_month        <= n_month;
        r_year         <= n_year;
        r_slot         <= n_slot;
        r_idx          <= n_idx;
        r_cnt          <= n_cnt;
        r_min          <= n_min;
        r_count        <= n_count;
        r_same         <= n_same;
        r_changed      <= n_changed;
        r_rejected     <= n_rejected;
        r_out_offset   <= n_out_offset;
        r_out_persist  <= n_out_persist;
        r_out_rejected <= n_out_rejected;
    end

    assign o_in_stall         = (r_state != S_IDLE);
    assign o_out_valid        = r_out_valid;
    assign o_offset_ppm       = r_out_offset;
    assign o_persist_needed   = r_out_persist;
    assign o_reading_rejected = r_out_rejected;

endmodule

// ===== rtl/co2bc_checker.sv =====
// co2bc_checker: port-level assertions for co2_baseline_calibrator
// depends on co2bc_pkg; attached to the top level by the bind below

module co2bc_checker
    import co2bc_pkg::*;
(
    input logic                    i_clk,
    input logic                    i_rst_n,
    input logic                    i_in_valid,
    input logic                    o_in_stall,
    input logic                    o_out_valid,
    input logic                    i_out_stall,
    input logic signed [PPM_W-1:0] o_offset_ppm,
    input logic                    o_persist_needed,
    input logic                    o_reading_rejected
);

    // a rejected reading never changes stored state
    a_reject_no_persist: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_reading_rejected |-> !o_persist_needed)
        else $error("rejected reading flagged persist");

    // one item in work at a time
    a_busy_after_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("input not stalled after transfer");

    // no result while the block has taken nothing yet after reset
    a_idle_after_reset: assert property (@(posedge i_clk)
        $rose(i_rst_n) |-> !o_out_valid)
        else $error("result shown right after reset");

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_offset_ppm)
            && $stable(o_persist_needed) && $stable(o_reading_rejected))
        else $error("stalled result changed");

endmodule

bind co2_baseline_calibrator co2bc_checker u_co2bc_checker (
    .i_clk              (i_clk),
    .i_rst_n            (i_rst_n),
    .i_in_valid         (i_in_valid),
    .o_in_stall         (o_in_stall),
    .o_out_valid        (o_out_valid),
    .i_out_stall        (i_out_stall),
    .o_offset_ppm       (o_offset_ppm),
    .o_persist_needed   (o_persist_needed),
    .o_reading_rejected (o_reading_rejected)
);

// ===== sim/co2_baseline_calibrator_tb.sv =====
// co2_baseline_calibrator_tb: self-checking bench for the co2 baseline calibrator
// drives readings and apb register writes, predicts every result in-bench
// depends on co2bc_pkg and co2_baseline_calibrator

`timescale 1ns / 100ps

module co2_baseline_calibrator_tb;
    import co2bc_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int LAST_STAMP     = 1023 * 12 + 11;

    typedef struct packed {
        logic [PPM_W-1:0]   ppm;
        logic [MONTH_W-1:0] mon;
        logic [YEAR_W-1:0]  yr;
    } t_reading;

    typedef struct packed {
        logic [PPM_W-1:0] offset;
        logic             persist;
        logic             rejected;
    } t_calib;

    logic                    i_clk              = 1'b0;
    logic                    i_rst_n            = 1'b0;
    logic                    psel               = 1'b0;
    logic                    penable            = 1'b0;
    logic                    pwrite             = 1'b0;
    logic [PADDR_W-1:0]      paddr              = '0;
    logic [PDATA_W-1:0]      pwdata             = '0;
    logic [PDATA_W-1:0]      prdata;
    logic                    pready;
    logic                    i_in_valid         = 1'b0;
    logic                    o_in_stall;
    logic [PPM_W-1:0]        i_reading_ppm      = '0;
    logic [MONTH_W-1:0]      i_month_index      = '0;
    logic [YEAR_W-1:0]       i_year_index       = '0;
    logic                    o_out_valid;
    logic                    i_out_stall        = 1'b0;
    logic signed [PPM_W-1:0] o_offset_ppm;
    logic                    o_persist_needed;
    logic                    o_reading_rejected;

    co2_baseline_calibrator dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .psel               (psel),
        .penable            (penable),
        .pwrite             (pwrite),
        .paddr              (paddr),
        .pwdata             (pwdata),
        .prdata             (prdata),
        .pready             (pready),
        .i_in_valid         (i_in_valid),
        .o_in_stall         (o_in_stall),
        .i_reading_ppm      (i_reading_ppm),
        .i_month_index      (i_month_index),
        .i_year_index       (i_year_index),
        .o_out_valid        (o_out_valid),
        .i_out_stall        (i_out_stall),
        .o_offset_ppm       (o_offset_ppm),
        .o_persist_needed   (o_persist_needed),
        .o_reading_rejected (o_reading_rejected)
    );

    always #5 i_clk = ~i_clk;

    // predictor copy of registers and state
    logic [PPM_W-1:0]  floor_ppm;
    logic [LOOK_W-1:0] look_cfg;
    logic [LOOK_W-1:0] need_cfg;
    logic [BASE_W-1:0] base_ppm;
    logic [YEAR_W-1:0] base_yr;
    logic [GROW_W-1:0] growth;
    logic [PPM_W-1:0]  ring [MONTH_SLOTS];
    logic [15:0]       last_stamp;
    logic [PPM_W-1:0]  held_offset;

    t_reading reading_q[$];
    t_calib   pending_offsets[$];

    int  mismatches   = 0;
    int  results_seen = 0;
    int  idle_cycles  = 0;
    int  send_gap     = 0;
    int  send_calm    = 0;
    int  recv_wait    = 0;
    int  recv_calm    = 0;
    int  cal_stamp    = 0;
    bit  send_hold    = 1'b0;
    bit  in_taken     = 1'b0;
    bit  out_taken    = 1'b0;

    function automatic void clear_calibration();
        floor_ppm   = RST_MIN_VALID;
        look_cfg    = RST_LOOKBACK;
        need_cfg    = RST_REQUIRED;
        base_ppm    = RST_BASELINE;
        base_yr     = RST_BASE_YEAR;
        growth      = RST_GROWTH;
        for (int k = 0; k < MONTH_SLOTS; k++) ring[k] = '0;
        last_stamp  = '0;
        held_offset = '0;
    endfunction

    function automatic t_calib calibrate(logic [PPM_W-1:0] rd, logic [MONTH_W-1:0] mon,
                                         logic [YEAR_W-1:0] yr);
        t_calib r;
        int     stamp, slot, gap, look, need, cnt, lo, off, v;
        bit     chg;
        chg        = 1'b0;
        r.rejected = 1'b0;
        if (rd < floor_ppm) begin
            r.offset   = held_offset;
            r.persist  = 1'b0;
            r.rejected = 1'b1;
            return r;
        end
        stamp = int'(yr) * 12 + int'(mon);
        slot  = stamp % MONTH_SLOTS;
        if (stamp == int'(last_stamp)) begin
            if (ring[slot] == '0 || ring[slot] > rd) begin
                ring[slot] = rd;
                chg        = 1'b1;
            end
        end else begin
            if (stamp > int'(last_stamp)) begin
                gap = stamp - int'(last_stamp) - 1;
                if (gap > MONTH_SLOTS - 1) gap = MONTH_SLOTS - 1;
                for (int k = 1; k <= gap; k++) ring[(slot + MONTH_SLOTS - k) % MONTH_SLOTS] = '0;
            end
            last_stamp = 16'(stamp);
            ring[slot] = rd;
            chg        = 1'b1;
        end
        look = int'(look_cfg);
        if (look < 1) look = 1;
        if (look > MONTH_SLOTS) look = MONTH_SLOTS;
        need = int'(need_cfg);
        if (need < 1) need = 1;
        lo  = 32'hFFFF;
        cnt = 0;
        for (int k = 0; k < look; k++) begin
            v = int'(ring[(slot + MONTH_SLOTS - k) % MONTH_SLOTS]);
            if (v > 0) begin
                if (v < lo) lo = v;
                cnt++;
            end
        end
        if (cnt >= need) begin
            off = int'(base_ppm) + (int'(yr) - int'(base_yr)) * int'(growth) - lo;
            if (PPM_W'(off) != held_offset) begin
                held_offset = PPM_W'(off);
                chg         = 1'b1;
            end
        end
        r.offset  = held_offset;
        r.persist = chg;
        return r;
    endfunction

    function automatic int draw_wait(inout int calm);
        int w;
        if (calm > 0) begin
            calm--;
            w = 0;
        end else begin
            if ($urandom_range(0, 24) == 0) calm = $urandom_range(10, 40);
            w = $urandom_range(0, 15);
        end
        return w;
    endfunction

    task automatic flag_mismatch(input string what, input int got, input int want);
        $display("%0t ns: mismatch on %s: got %0d, expected %0d", $time, what, got, want);
        mismatches++;
    endtask

    // input driver
    always @(negedge i_clk) begin
        t_reading nxt;
        if (i_rst_n && (!i_in_valid || in_taken)) begin
            if (send_gap > 0) begin
                send_gap--;
                i_in_valid <= 1'b0;
            end else if (reading_q.size() != 0 && !send_hold) begin
                nxt = reading_q.pop_front();
                i_in_valid    <= 1'b1;
                i_reading_ppm <= nxt.ppm;
                i_month_index <= nxt.mon;
                i_year_index  <= nxt.yr;
                send_gap = draw_wait(send_calm);
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // result stall
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (out_taken) recv_wait = draw_wait(recv_calm);
            i_out_stall <= (recv_wait > 0);
            if (o_out_valid && recv_wait > 0) recv_wait--;
        end
    end

    // monitor and checker
    always @(posedge i_clk) begin
        t_calib due;
        if (!i_rst_n) begin
            in_taken  <= 1'b0;
            out_taken <= 1'b0;
        end else begin
            in_taken  <= i_in_valid && !o_in_stall;
            out_taken <= o_out_valid && !i_out_stall;
            if (i_in_valid && !o_in_stall)
                pending_offsets.push_back(calibrate(i_reading_ppm, i_month_index, i_year_index));
            if (o_out_valid && !i_out_stall) begin
                results_seen++;
                if (pending_offsets.size() == 0) begin
                    flag_mismatch("result with no transfer pending", int'(o_offset_ppm), 0);
                end else begin
                    due = pending_offsets.pop_front();
                    if (o_offset_ppm !== due.offset)
                        flag_mismatch("offset_ppm", int'($signed(o_offset_ppm)),
                                      int'($signed(due.offset)));
                    if (o_persist_needed !== due.persist)
                        flag_mismatch("persist_needed", int'(o_persist_needed), int'(due.persist));
                    if (o_reading_rejected !== due.rejected)
                        flag_mismatch("reading_rejected", int'(o_reading_rejected),
                                      int'(due.rejected));
                end
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) || (psel && penable)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("co2_baseline_calibrator_tb: FAIL");
                $finish;
            end
        end
    end

    task automatic wait_idle();
        do @(posedge i_clk);
        while (reading_q.size() != 0 || i_in_valid || pending_offsets.size() != 0);
    endtask

    task automatic apb_write(input t_reg_idx idx, input logic [PDATA_W-1:0] val);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= PADDR_W'(4 * int'(idx));
        pwdata  <= val;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        case (idx)
            REG_MIN_VALID: floor_ppm = val[PPM_W-1:0];
            REG_LOOKBACK:  look_cfg  = val[LOOK_W-1:0];
            REG_REQUIRED:  need_cfg  = val[LOOK_W-1:0];
            REG_BASELINE:  base_ppm  = val[BASE_W-1:0];
            REG_BASE_YEAR: base_yr   = val[YEAR_W-1:0];
            REG_GROWTH:    growth    = val[GROW_W-1:0];
            default: ;
        endcase
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic set_config(input int flr, input int look, input int need, input int base,
                              input int byr, input int grow);
        wait_idle();
        repeat (8) @(posedge i_clk);
        apb_write(REG_MIN_VALID, PDATA_W'(flr));
        apb_write(REG_LOOKBACK,  PDATA_W'(look));
        apb_write(REG_REQUIRED,  PDATA_W'(need));
        apb_write(REG_BASELINE,  PDATA_W'(base));
        apb_write(REG_BASE_YEAR, PDATA_W'(byr));
        apb_write(REG_GROWTH,    PDATA_W'(grow));
        @(posedge i_clk);
    endtask

    task automatic queue_one(input int ppm, input int mon, input int yr);
        t_reading r;
        r.ppm = PPM_W'(ppm);
        r.mon = MONTH_W'(mon);
        r.yr  = YEAR_W'(yr);
        reading_q.push_back(r);
    endtask

    // mostly month-by-month sequences, with jumps, rewinds and noise mixed in
    task automatic queue_readings(input int n);
        int pick, ppm, mon, yr;
        for (int i = 0; i < n; i++) begin
            pick = $urandom_range(0, 99);
            if (pick >= 45 && pick < 75) cal_stamp += 1;
            else if (pick >= 75 && pick < 83) cal_stamp += $urandom_range(2, 14);
            else if (pick >= 83 && pick < 88) cal_stamp -= $urandom_range(1, 13);
            else if (pick >= 88 && pick < 91) cal_stamp = $urandom_range(0, LAST_STAMP);
            if (cal_stamp < 0) cal_stamp = 0;
            if (cal_stamp > LAST_STAMP) cal_stamp = $urandom_range(0, LAST_STAMP);
            yr  = cal_stamp / 12;
            mon = cal_stamp % 12;
            if (mon < 4 && yr > 0 && $urandom_range(0, 7) == 0) begin
                yr  = yr - 1;
                mon = mon + 12;
            end
            if (pick >= 94) begin
                mon = $urandom_range(0, 15);
                yr  = $urandom_range(0, 1023);
            end
            pick = $urandom_range(0, 99);
            if (pick < 8 && floor_ppm != '0) ppm = $urandom_range(0, int'(floor_ppm) - 1);
            else if (pick < 14) ppm = $urandom_range(0, 65535);
            else if (pick < 17) ppm = 65535;
            else begin
                ppm = int'(floor_ppm) + $urandom_range(0, 2500);
                if (ppm > 65535) ppm = 65535;
            end
            queue_one(ppm, mon, yr);
        end
    endtask

    initial begin
        int base_seen;
        clear_calibration();
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // defaults: floor edges, empty slot refill, ring fill, month wrap, rewinds, long gap
        queue_one(0, 0, 0);
        queue_one(199, 0, 0);
        queue_one(200, 0, 0);
        queue_one(65535, 0, 0);
        queue_one(201, 0, 0);
        queue_one(500, 1, 0);
        queue_one(450, 1, 0);
        queue_one(600, 2, 0);
        queue_one(700, 3, 0);
        queue_one(800, 4, 0);
        queue_one(800, 4, 0);
        queue_one(900, 15, 0);
        queue_one(350, 13, 0);
        queue_one(1000, 3, 1);
        queue_one(65535, 11, 1023);
        queue_one(65535, 15, 1023);
        queue_one(40000, 12, 1023);
        queue_one(16'hAAAA, 10, 10'h2AA);
        queue_one(16'h5555, 5, 10'h155);
        wait_idle();
        cal_stamp = 0;
        queue_readings(200);
        base_seen = results_seen;
        do @(posedge i_clk); while (results_seen < base_seen + 60 && reading_q.size() != 0);
        send_hold = 1'b1;
        do @(posedge i_clk); while (i_in_valid || pending_offsets.size() != 0);
        repeat (5) @(posedge i_clk);
        send_hold = 1'b0;

        set_config(0, 12, 1, 4095, 0, 15);
        queue_one(0, 3, 500);
        queue_one(0, 3, 500);
        queue_one(1, 4, 500);
        queue_readings(150);

        set_config(65535, 1, 12, 0, 1023, 0);
        queue_one(65534, 0, 0);
        queue_one(65535, 0, 0);
        queue_readings(100);

        set_config(1000, 0, 0, 0, 1023, 15);
        queue_one(65535, 0, 0);
        queue_readings(150);

        set_config(200, 15, 12, 2048, 512, 7);
        cal_stamp = 6000;
        queue_readings(100);

        for (int p = 0; p < 6; p++) begin
            set_config($urandom_range(0, 1500), $urandom_range(0, 15), $urandom_range(0, 8),
                       $urandom_range(0, 4095), $urandom_range(0, 1023), $urandom_range(0, 15));
            queue_readings(90);
        end

        wait_idle();
        repeat (40) @(posedge i_clk);
        if (pending_offsets.size() != 0)
            flag_mismatch("results never delivered", 0, pending_offsets.size());
        if (mismatches == 0) begin
            $display("co2_baseline_calibrator_tb: PASS");
        end else begin
            $display("co2_baseline_calibrator_tb: FAIL");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/co2bc_pkg.sv
rtl/co2bc_ring.sv
rtl/co2bc_core.sv
rtl/co2_baseline_calibrator.sv
rtl/co2bc_checker.sv
sim/co2_baseline_calibrator_tb.sv
